// ----- rtl/gso_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package gso_pkg;
   localparam int IN_WIDTH_DEF = 16;
   localparam int OUT_W        = 16;
   localparam int OUT_FRAC     = 14;
   localparam int OUT_ONE      = 16384;
   localparam int RND_HALF     = 8192;
   localparam int SCL_W        = 30;
   localparam int SQRT_STEPS   = SCL_W + 2;
   localparam int DIV_STEPS    = OUT_FRAC + 2;
   localparam int NORM_LAT     = 6 + SQRT_STEPS + DIV_STEPS;
   localparam int MID_STAGES   = 4;
endpackage
`default_nettype wire

// ----- rtl/gso_norm.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gso_norm import gso_pkg::*; #(
   parameter int RW  = 16,
   parameter int THR = 13,
   parameter int PW  = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [RW-1:0]    in_w [3],
   input  logic        [PW-1:0]    in_side,
   output logic                    out_valid,
   output logic signed [OUT_W-1:0] out_o [3],
   output logic                    out_deg,
   output logic        [PW-1:0]    out_side
);
   localparam int LIM = (THR + 1) / 2;
   localparam int SQW = 2 * LIM;
   localparam int SSW = SQW + 2;
   localparam int BLW = $clog2(RW + 1);
   localparam int NW  = 2 * SQRT_STEPS - 1;
   localparam int RTW = SCL_W + 1;
   localparam int NST = 5 + SQRT_STEPS + DIV_STEPS;
   localparam int NSC = 3 + SQRT_STEPS;
   localparam int DV0 = 5 + SQRT_STEPS;

   typedef struct packed {
      logic [PW-1:0] side;
      logic [2:0]    sgn;
      logic          deg;
   } ctl_type;

   logic [NST-1:0] vld_ff, vld_in;
   ctl_type        cm_ff [NST];
   ctl_type        cm_in [NST];

   logic [RW-1:0]      mag_ff [3], mag_in [3];
   logic [RW-1:0]      max_ff, max_in;
   logic [RW-1:0]      magb_ff [3], magb_in [3];
   logic [BLW-1:0]     bl_ff, bl_in;
   logic               small_ff, small_in;
   logic [SQW-1:0]     sq_ff [3], sq_in [3];
   logic [SCL_W-1:0]   scl_ff [NSC][3];
   logic [SCL_W-1:0]   scl_in [NSC][3];
   logic [2*SCL_W-1:0] ssq_ff [3], ssq_in [3];
   logic [NW-1:0]      s_ff, s_in;
   logic [NW-1:0]      n_ff [SQRT_STEPS], n_in [SQRT_STEPS];
   logic [NW-1:0]      r_ff [SQRT_STEPS], r_in [SQRT_STEPS];
   logic [RTW-1:0]     rem_ff [DIV_STEPS][3];
   logic [RTW-1:0]     rem_in [DIV_STEPS][3];
   logic [DIV_STEPS-1:0] q_ff [DIV_STEPS][3];
   logic [DIV_STEPS-1:0] q_in [DIV_STEPS][3];
   logic [RTW-1:0]     dv_ff [DIV_STEPS], dv_in [DIV_STEPS];
   logic               ov_ff, ov_in;
   logic signed [OUT_W-1:0] o_ff [3], o_in [3];
   logic               deg_ff, deg_in;
   logic [PW-1:0]      side_ff, side_in;

   always_comb begin
      logic [SSW-1:0]   sqsum;
      logic [NW-1:0]    nprev, rprev, bitv, sm;
      logic [RTW-1:0]   dv, rprv, rt;
      logic [RTW:0]     t;
      logic             dbit, ge;
      logic [DIV_STEPS-1:0] qprev;
      logic [DIV_STEPS:0]   qr;
      logic [OUT_W-1:0] qs;
      vld_in = {vld_ff[NST-2:0], in_valid};
      cm_in[0].side = in_side;
      cm_in[0].sgn  = {in_w[2][RW-1], in_w[1][RW-1], in_w[0][RW-1]};
      cm_in[0].deg  = 1'b0;
      for (int k = 1; k < NST; k++) cm_in[k] = cm_ff[k-1];

      for (int i = 0; i < 3; i++)
         mag_in[i] = in_w[i][RW-1] ? RW'(-in_w[i]) : RW'(in_w[i]);
      max_in = mag_in[0];
      if (mag_in[1] > max_in) max_in = mag_in[1];
      if (mag_in[2] > max_in) max_in = mag_in[2];

      bl_in = '0;
      for (int b = 0; b < RW; b++)
         if (max_ff[b]) bl_in = BLW'(b + 1);
      small_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         magb_in[i] = mag_ff[i];
         if ((mag_ff[i] >> LIM) != '0) small_in = 1'b0;
         sq_in[i] = SQW'(mag_ff[i][LIM-1:0]) * SQW'(mag_ff[i][LIM-1:0]);
      end

      for (int i = 0; i < 3; i++)
         scl_in[0][i] = SCL_W'({magb_ff[i], {SCL_W{1'b0}}} >> bl_ff);
      sqsum = SSW'(sq_ff[0]) + SSW'(sq_ff[1]) + SSW'(sq_ff[2]);
      cm_in[2].deg = small_ff && (sqsum < (SSW'(1) << THR));

      for (int k = 1; k < NSC; k++) scl_in[k] = scl_ff[k-1];
      for (int i = 0; i < 3; i++)
         ssq_in[i] = (2*SCL_W)'(scl_ff[0][i]) * (2*SCL_W)'(scl_ff[0][i]);
      s_in = NW'(ssq_ff[0]) + NW'(ssq_ff[1]) + NW'(ssq_ff[2]);

      for (int j = 0; j < SQRT_STEPS; j++) begin
         nprev = (j == 0) ? s_ff : n_ff[(j == 0) ? 0 : j-1];
         rprev = (j == 0) ? '0 : r_ff[(j == 0) ? 0 : j-1];
         bitv  = NW'(1) << (NW - 1 - 2*j);
         sm    = rprev + bitv;
         if (nprev >= sm) begin
            n_in[j] = nprev - sm;
            r_in[j] = (rprev >> 1) + bitv;
         end else begin
            n_in[j] = nprev;
            r_in[j] = rprev >> 1;
         end
      end

      rt = r_ff[SQRT_STEPS-1][RTW-1:0];
      for (int d = 0; d < DIV_STEPS; d++) begin
         dv = (d == 0) ? ((rt == '0) ? RTW'(1) : rt) : dv_ff[(d == 0) ? 0 : d-1];
         dv_in[d] = dv;
         for (int i = 0; i < 3; i++) begin
            if (d == 0) begin
               rprv  = RTW'(scl_ff[NSC-1][i][SCL_W-1:1]);
               dbit  = scl_ff[NSC-1][i][0];
               qprev = '0;
            end else begin
               rprv  = rem_ff[(d == 0) ? 0 : d-1][i];
               dbit  = 1'b0;
               qprev = q_ff[(d == 0) ? 0 : d-1][i];
            end
            t  = {rprv, dbit};
            ge = (t >= {1'b0, dv});
            rem_in[d][i] = ge ? RTW'(t - {1'b0, dv}) : RTW'(t);
            q_in[d][i]   = {qprev[DIV_STEPS-2:0], ge};
         end
      end

      ov_in   = vld_ff[NST-1];
      deg_in  = cm_ff[NST-1].deg;
      side_in = cm_ff[NST-1].side;
      for (int i = 0; i < 3; i++) begin
         qr = ({1'b0, q_ff[DIV_STEPS-1][i]} + (DIV_STEPS+1)'(1)) >> 1;
         qs = (qr > (DIV_STEPS+1)'(OUT_ONE)) ? OUT_W'(OUT_ONE) : OUT_W'(qr);
         if (cm_ff[NST-1].deg)
            o_in[i] = '0;
         else
            o_in[i] = cm_ff[NST-1].sgn[i] ? -$signed(qs) : $signed(qs);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         ov_ff  <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cm_ff    <= cm_in;
      mag_ff   <= mag_in;
      max_ff   <= max_in;
      magb_ff  <= magb_in;
      bl_ff    <= bl_in;
      small_ff <= small_in;
      sq_ff    <= sq_in;
      scl_ff   <= scl_in;
      ssq_ff   <= ssq_in;
      s_ff     <= s_in;
      n_ff     <= n_in;
      r_ff     <= r_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      dv_ff    <= dv_in;
      o_ff     <= o_in;
      deg_ff   <= deg_in;
      side_ff  <= side_in;
   end

   assign out_valid = ov_ff;
   assign out_o     = o_ff;
   assign out_deg   = deg_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

// ----- rtl/gram_schmidt_orthonormalize_3x3.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Classical Gram-Schmidt on three Q2.13 vectors, results in Q1.14. One request
// is taken every cycle (busy stays low) and its result strobes out one cycle
// wide; the receiver cannot stall, so results must be taken as they appear.
// The depth comes from three normalisers in series, each with a 32-stage
// bit-per-stage square root and a 16-stage restoring divider.
module gram_schmidt_orthonormalize_3x3 import gso_pkg::*; #(
   parameter int IN_WIDTH = IN_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [IN_WIDTH-1:0] req_first_vec_0,
   input  logic signed [IN_WIDTH-1:0] req_first_vec_1,
   input  logic signed [IN_WIDTH-1:0] req_first_vec_2,
   input  logic signed [IN_WIDTH-1:0] req_second_vec_0,
   input  logic signed [IN_WIDTH-1:0] req_second_vec_1,
   input  logic signed [IN_WIDTH-1:0] req_second_vec_2,
   input  logic signed [IN_WIDTH-1:0] req_third_vec_0,
   input  logic signed [IN_WIDTH-1:0] req_third_vec_1,
   input  logic signed [IN_WIDTH-1:0] req_third_vec_2,
   output logic                       rsp_strobe,
   output logic signed [OUT_W-1:0]    rsp_out_first_0,
   output logic signed [OUT_W-1:0]    rsp_out_first_1,
   output logic signed [OUT_W-1:0]    rsp_out_first_2,
   output logic signed [OUT_W-1:0]    rsp_out_second_0,
   output logic signed [OUT_W-1:0]    rsp_out_second_1,
   output logic signed [OUT_W-1:0]    rsp_out_second_2,
   output logic signed [OUT_W-1:0]    rsp_out_third_0,
   output logic signed [OUT_W-1:0]    rsp_out_third_1,
   output logic signed [OUT_W-1:0]    rsp_out_third_2,
   output logic        [2:0]          rsp_degenerate
);
   localparam int W    = IN_WIDTH;
   localparam int FIN  = W - 3;
   localparam int DW   = W + OUT_W;
   localparam int TW   = OUT_W + DW;
   localparam int RW   = W + 17;
   localparam int PW1  = 6 * W;
   localparam int PW2  = 3 * OUT_W + 3 * W + DW + 1;
   localparam int PW3  = 6 * OUT_W + 2;
   localparam int LAT  = 1 + 3 * NORM_LAT + 2 * MID_STAGES;

   function automatic logic signed [RW-1:0] rnd14(input logic signed [TW-1:0] p);
      logic [TW-1:0] mg;
      logic [TW:0]   sm;
      mg = p[TW-1] ? TW'(-p) : TW'(p);
      sm = {1'b0, mg} + (TW+1)'(RND_HALF);
      rnd14 = p[TW-1] ? -RW'(sm[TW:OUT_FRAC]) : RW'(sm[TW:OUT_FRAC]);
   endfunction

   logic               iv_ff, iv_in;
   logic signed [W-1:0] a_ff [3], a_in [3], b_ff [3], b_in [3], c_ff [3], c_in [3];
   logic [PW1-1:0]     side1;

   logic               n1v, dgn1;
   logic signed [OUT_W-1:0] xn1 [3];
   logic [PW1-1:0]     sn1;

   logic [MID_STAGES-1:0] pv_ff, pv_in, qv_ff, qv_in;
   logic signed [OUT_W-1:0] x1_ff [3], x1_in [3], x2_ff [3], x2_in [3];
   logic signed [OUT_W-1:0] x3_ff [3], x3_in [3], x4_ff [3], x4_in [3];
   logic signed [W-1:0] b1_ff [3], b1_in [3], b2_ff [3], b2_in [3], b3_ff [3], b3_in [3];
   logic signed [W-1:0] c1_ff [3], c1_in [3], c2_ff [3], c2_in [3];
   logic signed [W-1:0] c3_ff [3], c3_in [3], c4_ff [3], c4_in [3];
   logic signed [DW-1:0] px_ff [3], px_in [3], pc_ff [3], pc_in [3];
   logic signed [DW-1:0] d0_ff, d0_in, d1a_ff, d1a_in, d1b_ff, d1b_in, d1c_ff, d1c_in;
   logic signed [TW-1:0] t0_ff [3], t0_in [3];
   logic signed [RW-1:0] rb_ff [3], rb_in [3];
   logic [MID_STAGES-1:0] pdg_ff, pdg_in;
   logic [PW2-1:0]     side2;

   logic               n2v, dgn2;
   logic signed [OUT_W-1:0] yn2 [3], xs2 [3];
   logic signed [W-1:0] cs2 [3];
   logic signed [DW-1:0] d1s2;
   logic [PW2-1:0]     sn2;

   logic signed [OUT_W-1:0] x5_ff [3], x5_in [3], x6_ff [3], x6_in [3];
   logic signed [OUT_W-1:0] x7_ff [3], x7_in [3], x8_ff [3], x8_in [3];
   logic signed [OUT_W-1:0] y5_ff [3], y5_in [3], y6_ff [3], y6_in [3];
   logic signed [OUT_W-1:0] y7_ff [3], y7_in [3], y8_ff [3], y8_in [3];
   logic signed [W-1:0] c5_ff [3], c5_in [3], c6_ff [3], c6_in [3], c7_ff [3], c7_in [3];
   logic signed [DW-1:0] py_ff [3], py_in [3];
   logic signed [DW-1:0] d2_ff, d2_in, d1e_ff, d1e_in, d1f_ff, d1f_in;
   logic signed [TW-1:0] tx_ff [3], tx_in [3], ty_ff [3], ty_in [3];
   logic signed [RW-1:0] rc_ff [3], rc_in [3];
   logic [1:0]         qdg_ff [MID_STAGES], qdg_in [MID_STAGES];
   logic [PW3-1:0]     side3;

   logic               n3v, dgn3;
   logic signed [OUT_W-1:0] zn3 [3], xs3 [3], ys3 [3];
   logic [PW3-1:0]     sn3;

   assign busy  = 1'b0;

   always_comb begin
      iv_in   = start;
      a_in[0] = req_first_vec_0;  a_in[1] = req_first_vec_1;  a_in[2] = req_first_vec_2;
      b_in[0] = req_second_vec_0; b_in[1] = req_second_vec_1; b_in[2] = req_second_vec_2;
      c_in[0] = req_third_vec_0;  c_in[1] = req_third_vec_1;  c_in[2] = req_third_vec_2;
      for (int i = 0; i < 3; i++) begin
         side1[i*W +: W]     = b_ff[i];
         side1[(3+i)*W +: W] = c_ff[i];
      end
   end

   gso_norm #(.RW(W), .THR(FIN), .PW(PW1)) u_norm_first (
      .clock(clock), .reset(reset),
      .in_valid(iv_ff), .in_w(a_ff), .in_side(side1),
      .out_valid(n1v), .out_o(xn1), .out_deg(dgn1), .out_side(sn1)
   );

   // projection on the first result, plus the third vector's dot product with it
   always_comb begin
      pv_in = {pv_ff[MID_STAGES-2:0], n1v};
      pdg_in = {pdg_ff[MID_STAGES-2:0], dgn1};
      for (int i = 0; i < 3; i++) begin
         x1_in[i] = xn1[i];
         b1_in[i] = $signed(sn1[i*W +: W]);
         c1_in[i] = $signed(sn1[(3+i)*W +: W]);
         px_in[i] = DW'(xn1[i]) * DW'(b1_in[i]);
         pc_in[i] = DW'(xn1[i]) * DW'(c1_in[i]);
         x2_in[i] = x1_ff[i]; b2_in[i] = b1_ff[i]; c2_in[i] = c1_ff[i];
         x3_in[i] = x2_ff[i]; b3_in[i] = b2_ff[i]; c3_in[i] = c2_ff[i];
         x4_in[i] = x3_ff[i]; c4_in[i] = c3_ff[i];
         t0_in[i] = TW'(x2_ff[i]) * TW'(d0_ff);
         rb_in[i] = (RW'(b3_ff[i]) <<< OUT_FRAC) - rnd14(t0_ff[i]);
      end
      d0_in  = px_ff[0] + px_ff[1] + px_ff[2];
      d1a_in = pc_ff[0] + pc_ff[1] + pc_ff[2];
      d1b_in = d1a_ff;
      d1c_in = d1b_ff;
      for (int i = 0; i < 3; i++) begin
         side2[i*OUT_W +: OUT_W]       = x4_ff[i];
         side2[3*OUT_W + i*W +: W]     = c4_ff[i];
      end
      side2[3*OUT_W + 3*W +: DW] = d1c_ff;
      side2[PW2-1]               = pdg_ff[MID_STAGES-1];
   end

   gso_norm #(.RW(RW), .THR(FIN + 28), .PW(PW2)) u_norm_second (
      .clock(clock), .reset(reset),
      .in_valid(pv_ff[MID_STAGES-1]), .in_w(rb_ff), .in_side(side2),
      .out_valid(n2v), .out_o(yn2), .out_deg(dgn2), .out_side(sn2)
   );

   // projections on the first and second results
   always_comb begin
      qv_in = {qv_ff[MID_STAGES-2:0], n2v};
      for (int i = 0; i < 3; i++) begin
         xs2[i] = $signed(sn2[i*OUT_W +: OUT_W]);
         cs2[i] = $signed(sn2[3*OUT_W + i*W +: W]);
      end
      d1s2 = $signed(sn2[3*OUT_W + 3*W +: DW]);
      qdg_in[0] = {dgn2, sn2[PW2-1]};
      for (int k = 1; k < MID_STAGES; k++) qdg_in[k] = qdg_ff[k-1];
      for (int i = 0; i < 3; i++) begin
         x5_in[i] = xs2[i]; y5_in[i] = yn2[i]; c5_in[i] = cs2[i];
         py_in[i] = DW'(yn2[i]) * DW'(cs2[i]);
         x6_in[i] = x5_ff[i]; y6_in[i] = y5_ff[i]; c6_in[i] = c5_ff[i];
         x7_in[i] = x6_ff[i]; y7_in[i] = y6_ff[i]; c7_in[i] = c6_ff[i];
         tx_in[i] = TW'(x6_ff[i]) * TW'(d1f_ff);
         ty_in[i] = TW'(y6_ff[i]) * TW'(d2_ff);
         x8_in[i] = x7_ff[i]; y8_in[i] = y7_ff[i];
         rc_in[i] = (RW'(c7_ff[i]) <<< OUT_FRAC) - rnd14(tx_ff[i]) - rnd14(ty_ff[i]);
      end
      d1e_in = d1s2;
      d1f_in = d1e_ff;
      d2_in  = py_ff[0] + py_ff[1] + py_ff[2];
      for (int i = 0; i < 3; i++) begin
         side3[i*OUT_W +: OUT_W]         = x8_ff[i];
         side3[(3+i)*OUT_W +: OUT_W]     = y8_ff[i];
      end
      side3[6*OUT_W +: 2] = qdg_ff[MID_STAGES-1];
   end

   gso_norm #(.RW(RW), .THR(FIN + 28), .PW(PW3)) u_norm_third (
      .clock(clock), .reset(reset),
      .in_valid(qv_ff[MID_STAGES-1]), .in_w(rc_ff), .in_side(side3),
      .out_valid(n3v), .out_o(zn3), .out_deg(dgn3), .out_side(sn3)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xs3[i] = $signed(sn3[i*OUT_W +: OUT_W]);
         ys3[i] = $signed(sn3[(3+i)*OUT_W +: OUT_W]);
      end
   end

   assign rsp_strobe       = n3v;
   assign rsp_out_first_0  = xs3[0];
   assign rsp_out_first_1  = xs3[1];
   assign rsp_out_first_2  = xs3[2];
   assign rsp_out_second_0 = ys3[0];
   assign rsp_out_second_1 = ys3[1];
   assign rsp_out_second_2 = ys3[2];
   assign rsp_out_third_0  = zn3[0];
   assign rsp_out_third_1  = zn3[1];
   assign rsp_out_third_2  = zn3[2];
   assign rsp_degenerate   = {dgn3, sn3[6*OUT_W +: 2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff <= 1'b0;
         pv_ff <= '0;
         qv_ff <= '0;
      end else begin
         iv_ff <= iv_in;
         pv_ff <= pv_in;
         qv_ff <= qv_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in;
      x1_ff <= x1_in; x2_ff <= x2_in; x3_ff <= x3_in; x4_ff <= x4_in;
      b1_ff <= b1_in; b2_ff <= b2_in; b3_ff <= b3_in;
      c1_ff <= c1_in; c2_ff <= c2_in; c3_ff <= c3_in; c4_ff <= c4_in;
      px_ff <= px_in; pc_ff <= pc_in;
      d0_ff <= d0_in; d1a_ff <= d1a_in; d1b_ff <= d1b_in; d1c_ff <= d1c_in;
      t0_ff <= t0_in; rb_ff <= rb_in; pdg_ff <= pdg_in;
      x5_ff <= x5_in; x6_ff <= x6_in; x7_ff <= x7_in; x8_ff <= x8_in;
      y5_ff <= y5_in; y6_ff <= y6_in; y7_ff <= y7_in; y8_ff <= y8_in;
      c5_ff <= c5_in; c6_ff <= c6_in; c7_ff <= c7_in;
      py_ff <= py_in; d2_ff <= d2_in; d1e_ff <= d1e_in; d1f_ff <= d1f_in;
      tx_ff <= tx_in; ty_ff <= ty_in; rc_ff <= rc_in; qdg_ff <= qdg_in;
   end

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without a matching request");

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_degenerate[0] |->
         rsp_out_first_0 == 0 && rsp_out_first_1 == 0 && rsp_out_first_2 == 0)
      else $error("degenerate first vector with non-zero output");

   a_third_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $signed(rsp_out_third_0) <= OUT_ONE &&
                     $signed(rsp_out_third_0) >= -OUT_ONE)
      else $error("third vector component out of range");
endmodule
`default_nettype wire

// ----- tb/tb_gram_schmidt_orthonormalize_3x3.sv -----
`timescale 1ns / 1ps
module tb_gram_schmidt_orthonormalize_3x3;
   import gso_pkg::*;

   typedef longint vec3_type [3];
   typedef struct {
      logic signed [15:0] comp [9];
      logic [2:0]         deg;
   } frame_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 400;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic signed [15:0] vin [9];
   logic rsp_strobe;
   logic signed [15:0] vout [9];
   logic [2:0] rsp_degenerate;

   frame_type frames_due [$];
   int     mismatches = 0;
   int     checked = 0;
   int     sent = 0;
   int     deg_seen = 0;
   int     quiet_cycles = 0;
   bit     no_idle = 1'b0;

   always #4 clock = ~clock;

   gram_schmidt_orthonormalize_3x3 dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_vec_0(vin[0]), .req_first_vec_1(vin[1]), .req_first_vec_2(vin[2]),
      .req_second_vec_0(vin[3]), .req_second_vec_1(vin[4]), .req_second_vec_2(vin[5]),
      .req_third_vec_0(vin[6]), .req_third_vec_1(vin[7]), .req_third_vec_2(vin[8]),
      .rsp_strobe(rsp_strobe),
      .rsp_out_first_0(vout[0]), .rsp_out_first_1(vout[1]), .rsp_out_first_2(vout[2]),
      .rsp_out_second_0(vout[3]), .rsp_out_second_1(vout[4]), .rsp_out_second_2(vout[5]),
      .rsp_out_third_0(vout[6]), .rsp_out_third_1(vout[7]), .rsp_out_third_2(vout[8]),
      .rsp_degenerate(rsp_degenerate)
   );

   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint round_shift14(longint p);
      longint q;
      q = longint'((magnitude(p) + 64'd8192) >> 14);
      return p < 0 ? -q : q;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bit unit_vector(vec3_type w, int frac, output vec3_type o);
      logic [63:0] a [3];
      logic [63:0] m, s, r, q;
      int thr, bl;
      m = 0;
      s = 0;
      thr = 2 * frac - 13;
      bl = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = magnitude(w[i]);
         if (a[i] > m) m = a[i];
      end
      if (m < (64'd1 << 31)) begin
         for (int i = 0; i < 3; i++) s = s + a[i] * a[i];
         if (s < (64'd1 << thr)) begin
            o[0] = 0; o[1] = 0; o[2] = 0;
            return 1'b1;
         end
      end
      while (bl < 64 && (m >> bl) != 0) bl++;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         if (bl > 30) a[i] = a[i] >> (bl - 30);
         else a[i] = a[i] << (30 - bl);
         s = s + a[i] * a[i];
      end
      r = int_sqrt(s);
      if (r == 0) r = 1;
      for (int i = 0; i < 3; i++) begin
         q = (((a[i] << 15) / r) + 64'd1) >> 1;
         if (q > OUT_ONE) q = OUT_ONE;
         o[i] = w[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b0;
   endfunction

   function automatic frame_type orthonormalise(logic signed [15:0] v [9]);
      vec3_type a, b, c, x, y, z, rb, rc;
      longint d0, d1, d2;
      frame_type f;
      for (int i = 0; i < 3; i++) begin
         a[i] = longint'(v[i]);
         b[i] = longint'(v[3 + i]);
         c[i] = longint'(v[6 + i]);
      end
      f.deg = 3'b000;
      f.deg[0] = unit_vector(a, 13, x);
      d0 = x[0] * b[0] + x[1] * b[1] + x[2] * b[2];
      for (int i = 0; i < 3; i++) rb[i] = b[i] * 16384 - round_shift14(x[i] * d0);
      f.deg[1] = unit_vector(rb, 27, y);
      d1 = x[0] * c[0] + x[1] * c[1] + x[2] * c[2];
      d2 = y[0] * c[0] + y[1] * c[1] + y[2] * c[2];
      for (int i = 0; i < 3; i++)
         rc[i] = c[i] * 16384 - round_shift14(x[i] * d1) - round_shift14(y[i] * d2);
      f.deg[2] = unit_vector(rc, 27, z);
      for (int i = 0; i < 3; i++) begin
         f.comp[i] = x[i][15:0];
         f.comp[3 + i] = y[i][15:0];
         f.comp[6 + i] = z[i][15:0];
      end
      return f;
   endfunction

   task automatic send_request(logic signed [15:0] v [9]);
      if (!no_idle) begin
         while ($urandom_range(99) < 7) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      for (int i = 0; i < 9; i++) vin[i] <= v[i];
      do @(posedge clock); while (busy);
      frames_due.insert(frames_due.size(), orthonormalise(v));
      sent++;
   endtask

   task automatic send_nine(int a0, a1, a2, b0, b1, b2, c0, c1, c2);
      logic signed [15:0] v [9];
      v[0] = 16'(a0); v[1] = 16'(a1); v[2] = 16'(a2);
      v[3] = 16'(b0); v[4] = 16'(b1); v[5] = 16'(b2);
      v[6] = 16'(c0); v[7] = 16'(c1); v[8] = 16'(c2);
      send_request(v);
   endtask

   task automatic test_extremes();
      send_nine(8192, 0, 0, 0, 8192, 0, 0, 0, 8192);
      send_nine(32767, 32767, 32767, -32768, -32768, -32768, 32767, -32768, 32767);
      send_nine(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768);
      send_nine(32767, 0, 0, 0, 32767, 0, 0, 0, 32767);
      send_nine(-1, -1, -1, 1, -1, 1, -1, 1, 1);
      send_nine(1, 0, 0, 0, 1, 0, 0, 0, 1);
      send_nine(0, 0, 32767, 0, 32767, 0, 32767, 0, 0);
      send_nine(5793, 5793, 0, -5793, 5793, 0, 0, 0, 8192);
   endtask

   task automatic test_degenerate_cases();
      send_nine(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_nine(0, 0, 0, 8192, 0, 0, 0, 8192, 0);
      send_nine(8192, 0, 0, 16384, 0, 0, 0, 0, 8192);
      send_nine(1000, 2000, 3000, -2000, -4000, -6000, 0, 8192, 0);
      send_nine(8192, 0, 0, 0, 8192, 0, 8192, 8192, 0);
      send_nine(8192, 0, 0, 0, 8192, 0, 123, -456, 0);
      send_nine(0, 0, 0, 0, 0, 0, 300, 400, 500);
      send_nine(90, 0, 0, 0, 91, 0, 0, 0, 90);
      send_nine(89, 0, 0, 0, 0, 1, 0, 0, 0);
      send_nine(1, 1, 1, 1, 1, 1, 1, 1, 1);
      send_nine(12345, -6789, 2222, 12345, -6789, 2222, -12345, 6789, -2222);
   endtask

   function automatic logic signed [15:0] rand_comp(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($signed(17'($urandom_range(400)) - 17'sd200));
         default: return 16'($signed(18'($urandom_range(16384)) - 18'sd8192));
      endcase
   endfunction

   task automatic test_random_mixed(int count);
      logic signed [15:0] v [9];
      int mode, k1, k2;
      for (int n = 0; n < count; n++) begin
         no_idle = (n >= count / 3) && (n < count / 3 + 400);
         mode = $urandom_range(2);
         for (int i = 0; i < 9; i++) v[i] = rand_comp(mode);
         case ($urandom_range(9))
            0: for (int i = 0; i < 3; i++) v[3 + i] = -v[i];
            1: for (int i = 0; i < 3; i++) v[3 + i] = 16'(int'(v[i]) / 2 + int'(v[3 + i]) % 3);
            2: for (int i = 0; i < 3; i++) v[6 + i] = 16'((int'(v[i]) + int'(v[3 + i])) / 2);
            3: begin
               k1 = $urandom_range(4) - 2;
               k2 = $urandom_range(4) - 2;
               for (int i = 0; i < 3; i++)
                  v[6 + i] = 16'((k1 * int'(v[i]) + k2 * int'(v[3 + i])) / 4
                                 + int'($urandom_range(2)) - 1);
            end
            4: v[$urandom_range(2)] = 16'($urandom_range(200)) - 16'sd100;
            default: ;
         endcase
         send_request(v);
      end
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      frame_type want, got;
      bit bad;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
         if (rsp_strobe) begin
            for (int i = 0; i < 9; i++) got.comp[i] = vout[i];
            got.deg = rsp_degenerate;
            if (frames_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
               want = frames_due.pop_front();
               bad = (got.deg !== want.deg);
               for (int i = 0; i < 9; i++) if (got.comp[i] !== want.comp[i]) bad = 1'b1;
               checked++;
               if (got.deg != 0) deg_seen++;
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch %0d: exp %p deg %b", checked, want.comp, want.deg);
                     $display("             got %p deg %b", got.comp, got.deg);
                  end
               end
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      for (int i = 0; i < 9; i++) vin[i] <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_degenerate_cases();
      test_random_mixed(1430);
      start <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests sent, %0d results checked, %0d with a degenerate vector",
               sent, checked, deg_seen);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0 && frames_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
